// File: hw/rtl/tgc_pkg.sv
// ----------------------------------------------------------------------------
// tgc_pkg
// Shared types, codes and helpers of the touch gesture classifier.
// ----------------------------------------------------------------------------
package tgc_pkg;

  localparam int unsigned TypeW  = 5;
  localparam int unsigned CodeW  = 10;
  localparam int unsigned ValueW = 12;
  localparam int unsigned PosW   = 12;
  localparam int unsigned CfgW   = 12;
  localparam int unsigned CfgIdxW = 2;

  // Event type and code values
  localparam logic [TypeW-1:0] TYPE_KEY   = 5'd1;
  localparam logic [TypeW-1:0] TYPE_ABS   = 5'd3;
  localparam logic [CodeW-1:0] CODE_X     = 10'd0;
  localparam logic [CodeW-1:0] CODE_Y     = 10'd1;
  localparam logic [CodeW-1:0] CODE_TOUCH = 10'd330;
  localparam logic [ValueW-1:0] TOUCH_UP   = 12'd0;
  localparam logic [ValueW-1:0] TOUCH_DOWN = 12'd1;

  // Screen scaling: x * 800 / 1024 = x * 25 / 32, y * 480 / 600 = (4 * y) / 5
  localparam int unsigned XMul   = 25;
  localparam int unsigned XShift = 5;
  localparam int unsigned YMul   = 4;
  // floor(n / 5) = (n * 26215) >> 17, exact for n < 2^14
  localparam int unsigned Div5Recip = 26215;
  localparam int unsigned Div5Shift = 17;

  // Configuration reset values
  localparam logic [CfgW-1:0] SWIPE_MIN_RST       = 12'd50;
  localparam logic [CfgW-1:0] LEFT_TAP_EDGE_RST   = 12'd200;
  localparam logic [CfgW-1:0] RIGHT_TAP_EDGE_RST  = 12'd600;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SWIPE_MIN       = 2'd0,
    CFG_LEFT_TAP_EDGE   = 2'd1,
    CFG_RIGHT_TAP_EDGE  = 2'd2,
    CFG_UNUSED          = 2'd3
  } cfg_idx_t;

  typedef enum logic [1:0] {
    GEST_NONE   = 2'd0,
    GEST_PREV   = 2'd1,
    GEST_NEXT   = 2'd2,
    GEST_TOGGLE = 2'd3
  } gesture_t;

  typedef enum logic [2:0] {
    EV_OTHER,
    EV_ABS_X,
    EV_ABS_Y,
    EV_TOUCH_DOWN,
    EV_TOUCH_UP
  } ev_kind_t;

  typedef struct packed {
    logic [PosW-1:0] now_x;
    logic [PosW-1:0] now_y;
    logic [PosW-1:0] origin_x;
    logic [PosW-1:0] origin_y;
  } pos_t;

  typedef struct packed {
    logic [CfgW-1:0] swipe_min;
    logic [CfgW-1:0] left_tap_edge;
    logic [CfgW-1:0] right_tap_edge;
  } cfg_t;

  function automatic ev_kind_t decode_event(
    input logic [TypeW-1:0]  ev_type,
    input logic [CodeW-1:0]  ev_code,
    input logic [ValueW-1:0] ev_value
  );
    ev_kind_t kind;
    kind = EV_OTHER;
    if (ev_type == TYPE_ABS && ev_code == CODE_X) begin
      kind = EV_ABS_X;
    end else if (ev_type == TYPE_ABS && ev_code == CODE_Y) begin
      kind = EV_ABS_Y;
    end else if (ev_type == TYPE_KEY && ev_code == CODE_TOUCH) begin
      if (ev_value == TOUCH_DOWN) begin
        kind = EV_TOUCH_DOWN;
      end else if (ev_value == TOUCH_UP) begin
        kind = EV_TOUCH_UP;
      end
    end
    return kind;
  endfunction

endpackage

// File: hw/rtl/tgc_if.sv
// ----------------------------------------------------------------------------
// tgc_if
// Valid/ready channels of the touch gesture classifier: raw events in,
// gesture results out.
// ----------------------------------------------------------------------------
interface tgc_in_if;
  logic                         valid;
  logic                         ready;
  logic [tgc_pkg::TypeW-1:0]    event_type;
  logic [tgc_pkg::CodeW-1:0]    event_code;
  logic [tgc_pkg::ValueW-1:0]   event_value;

  modport source (output valid, event_type, event_code, event_value, input ready);
  modport sink   (input valid, event_type, event_code, event_value, output ready);
endinterface

interface tgc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] gesture;

  modport source (output valid, gesture, input ready);
  modport sink   (input valid, gesture, output ready);
endinterface

// File: hw/rtl/tgc_position.sv
// ----------------------------------------------------------------------------
// tgc_position
// Current and origin position registers with the screen scaling of raw
// axis coordinates.
// ----------------------------------------------------------------------------
module tgc_position (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       advance,
  input  tgc_pkg::ev_kind_t          kind,
  input  logic [tgc_pkg::ValueW-1:0] value,
  output tgc_pkg::pos_t              pos
);

  localparam int unsigned XProdW = tgc_pkg::ValueW + 5;
  localparam int unsigned YNumW  = tgc_pkg::ValueW + 2;
  localparam int unsigned YProdW = YNumW + 15;

  tgc_pkg::pos_t pos_r;
  tgc_pkg::pos_t pos_nxt;

  logic [XProdW-1:0] x_prod;
  logic [YNumW-1:0]  y_num;
  logic [YProdW-1:0] y_prod;
  logic [tgc_pkg::PosW-1:0] x_scaled;
  logic [tgc_pkg::PosW-1:0] y_scaled;

  always_comb begin
    x_prod   = XProdW'(value) * XProdW'(tgc_pkg::XMul);
    x_scaled = tgc_pkg::PosW'(x_prod >> tgc_pkg::XShift);
    y_num    = YNumW'(value) * YNumW'(tgc_pkg::YMul);
    y_prod   = YProdW'(y_num) * YProdW'(tgc_pkg::Div5Recip);
    y_scaled = tgc_pkg::PosW'(y_prod >> tgc_pkg::Div5Shift);
  end

  always_comb begin
    pos_nxt = pos_r;
    if (advance) begin
      unique case (kind)
        tgc_pkg::EV_ABS_X: pos_nxt.now_x = x_scaled;
        tgc_pkg::EV_ABS_Y: pos_nxt.now_y = y_scaled;
        tgc_pkg::EV_TOUCH_DOWN: begin
          pos_nxt.origin_x = pos_r.now_x;
          pos_nxt.origin_y = pos_r.now_y;
        end
        default: pos_nxt = pos_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  assign pos = pos_r;

endmodule

// File: hw/rtl/tgc_classify.sv
// ----------------------------------------------------------------------------
// tgc_classify
// Swipe/tap decision from the current and origin positions.
// ----------------------------------------------------------------------------
module tgc_classify (
  input  tgc_pkg::pos_t    pos,
  input  tgc_pkg::cfg_t    cfg,
  output tgc_pkg::gesture_t gesture
);

  localparam int unsigned DiffW = tgc_pkg::PosW + 1;

  logic [DiffW-1:0]         dx;
  logic [DiffW-1:0]         dy;
  logic [tgc_pkg::PosW-1:0] ax;
  logic [tgc_pkg::PosW-1:0] ay;
  logic                     swipe;

  always_comb begin
    dx = DiffW'(pos.now_x) - DiffW'(pos.origin_x);
    dy = DiffW'(pos.now_y) - DiffW'(pos.origin_y);
    // Magnitude fits in 12 bits since both operands are 12-bit unsigned
    ax = dx[DiffW-1] ? tgc_pkg::PosW'(-dx) : dx[tgc_pkg::PosW-1:0];
    ay = dy[DiffW-1] ? tgc_pkg::PosW'(-dy) : dy[tgc_pkg::PosW-1:0];
    swipe = (ax > cfg.swipe_min) || (ay > cfg.swipe_min);

    gesture = tgc_pkg::GEST_NONE;
    if (swipe) begin
      if (ax > ay) begin
        // Mainly horizontal: ax exceeds the threshold here
        gesture = dx[DiffW-1] ? tgc_pkg::GEST_NEXT : tgc_pkg::GEST_PREV;
      end else if (ay > cfg.swipe_min) begin
        gesture = tgc_pkg::GEST_TOGGLE;
      end
    end else if (pos.origin_x < cfg.left_tap_edge) begin
      gesture = tgc_pkg::GEST_PREV;
    end else if (pos.origin_x > cfg.right_tap_edge) begin
      gesture = tgc_pkg::GEST_NEXT;
    end
  end

endmodule

// File: hw/rtl/touch_gesture_classifier_core.sv
// ----------------------------------------------------------------------------
// touch_gesture_classifier_core
// Turns a stream of raw touch events into swipe and tap gesture results.
// ----------------------------------------------------------------------------
// The core takes one raw event (type, code, value) per cycle and emits one
// gesture for every touch-up key event, through the input and then the output register; all
// other events only update the tracked position and emit nothing. Sustained
// rate is one item per clock: an event is held in the input register,
// where its position update and the gesture decision are done, and the
// result goes to a separate output register, so input keeps flowing while a
// result waits for out_ch.ready. Only a touch-up that finds the output
// register full and not being drained holds the input side. Absolute X/Y
// values are scaled to screen pixels (x*25/32 and 4*y/5, truncated); a
// touch-down latches the current position as the origin. Thresholds are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the core is idle, as the core does not enforce it; index 3 is ignored.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_core (
  input  logic                        clk,
  input  logic                        rst_n,
  tgc_in_if.sink                      in_ch,
  tgc_out_if.source                   out_ch,
  input  logic                        cfg_we,
  input  logic [tgc_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [tgc_pkg::CfgW-1:0]    cfg_data
);

  // Configuration registers
  tgc_pkg::cfg_t cfg_r;
  tgc_pkg::cfg_t cfg_nxt;

  // Input register
  logic                       in_valid_r;
  tgc_pkg::ev_kind_t          in_kind_r;
  logic [tgc_pkg::ValueW-1:0] in_value_r;

  // Output register
  logic              out_valid_r;
  logic              out_valid_nxt;
  tgc_pkg::gesture_t gesture_r;

  logic              advance;
  logic              emit;
  tgc_pkg::pos_t     pos;
  tgc_pkg::gesture_t gesture_calc;

  // Write configuration by index; ignore the spare index
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (tgc_pkg::cfg_idx_t'(cfg_index))
        tgc_pkg::CFG_SWIPE_MIN:       cfg_nxt.swipe_min       = cfg_data;
        tgc_pkg::CFG_LEFT_TAP_EDGE:   cfg_nxt.left_tap_edge   = cfg_data;
        tgc_pkg::CFG_RIGHT_TAP_EDGE:  cfg_nxt.right_tap_edge  = cfg_data;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swipe_min       <= tgc_pkg::SWIPE_MIN_RST;
      cfg_r.left_tap_edge   <= tgc_pkg::LEFT_TAP_EDGE_RST;
      cfg_r.right_tap_edge  <= tgc_pkg::RIGHT_TAP_EDGE_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Advance the held event unless it needs the output register and that
  // register is full and stalled
  assign emit    = in_valid_r && (in_kind_r == tgc_pkg::EV_TOUCH_UP);
  assign advance = in_valid_r && (!emit || !out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  // Decode at capture so only the event kind and value are held
  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_kind_r  <= tgc_pkg::decode_event(in_ch.event_type, in_ch.event_code,
                                          in_ch.event_value);
      in_value_r <= in_ch.event_value;
    end
  end

  tgc_position u_position (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .kind    (in_kind_r),
    .value   (in_value_r),
    .pos     (pos)
  );

  tgc_classify u_classify (
    .pos     (pos),
    .cfg     (cfg_r),
    .gesture (gesture_calc)
  );

  // Load a result on touch-up, drop it once taken
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ch.ready;
    if (advance && emit) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      gesture_r <= gesture_calc;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.gesture = gesture_r;

endmodule

// File: tb/sv/touch_gesture_classifier_core_tb.sv
// ----------------------------------------------------------------------------
// touch_gesture_classifier_core_tb
// Self-checking bench for the touch gesture classifier core. A directed
// event table covers the corner cases: release after reset, extreme
// coordinates, all four gestures, ignored events and the threshold boundary.
// Random press/move/release sequences with noise follow, under several
// threshold and tap-edge settings, with bursty input and a stalling
// receiver. A built-in tracker predicts every gesture not typed into the
// table, and each result is checked in order against the expected ones.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tgc_pkg::*;

  localparam int NumPhases     = 8;
  localparam int PhaseEvents   = 110;  // recognized events per random phase
  localparam int LongHold      = 400;  // receiver hold-off for the pressure test
  localparam int QuietLimit    = 3000; // watchdog: cycles without any handshake
  localparam int DrainCycles   = 4;    // result passes the input and output registers; add margin

  // One row of the directed table. When pinned is set, the expected gesture
  // is typed in; otherwise the tracker supplies it.
  typedef struct packed {
    logic [TypeW-1:0]  ev_type;
    logic [CodeW-1:0]  ev_code;
    logic [ValueW-1:0] ev_value;
    logic              pinned;
    gesture_t          gesture;
  } event_row_t;

  // Corner cases, starting from reset values (threshold 50, edges 200 / 600).
  event_row_t corner_events [26] = '{
    // release with no press: origin is zero, tap at the left side
    '{TYPE_KEY, CODE_TOUCH, TOUCH_UP,   1'b1, GEST_PREV},
    // full-scale position: x -> 3199, y -> 3276
    '{TYPE_ABS, CODE_X,     12'd4095,   1'b0, GEST_NONE},
    '{TYPE_ABS, CODE_Y,     12'd4095,   1'b0, GEST_NONE},
    '{TYPE_KEY, CODE_TOUCH, TOUCH_DOWN, 1'b0, GEST_NONE},
    // no movement: tap at the right side
    '{TYPE_KEY, CODE_TOUCH, TOUCH_UP,   1'b1, GEST_NEXT},
    // full swipe to the left
    '{TYPE_ABS, CODE_X,     12'd0,      1'b0, GEST_NONE},
    '{TYPE_KEY, CODE_TOUCH, TOUCH_UP,   1'b1, GEST_NEXT},
    // full vertical swipe
    '{TYPE_KEY, CODE_TOUCH, TOUCH_DOWN, 1'b0, GEST_NONE},
    '{TYPE_ABS, CODE_Y,     12'd0,      1'b0, GEST_NONE},
    '{TYPE_KEY, CODE_TOUCH, TOUCH_UP,   1'b1, GEST_TOGGLE},
    // full swipe to the right
    '{TYPE_KEY, CODE_TOUCH, TOUCH_DOWN, 1'b0, GEST_NONE},
    '{TYPE_ABS, CODE_X,     12'd4095,   1'b0, GEST_NONE},
    '{TYPE_KEY, CODE_TOUCH, TOUCH_UP,   1'b1, GEST_PREV},
    // tap in the middle band still emits a result
    '{TYPE_ABS, CODE_X,     12'd512,    1'b0, GEST_NONE},
    '{TYPE_ABS, CODE_Y,     12'd300,    1'b0, GEST_NONE},
    '{TYPE_KEY, CODE_TOUCH, TOUCH_DOWN, 1'b0, GEST_NONE},
    '{TYPE_KEY, CODE_TOUCH, TOUCH_UP,   1'b1, GEST_NONE},
    // touch button with a value other than up or down
    '{TYPE_KEY, CODE_TOUCH, 12'd2,      1'b0, GEST_NONE},
    '{TYPE_KEY, CODE_TOUCH, 12'd4095,   1'b0, GEST_NONE},
    // unknown type/code combinations
    '{5'd0,     10'd0,      12'd4095,   1'b0, GEST_NONE},
    '{5'd31,    10'd1023,   12'd4095,   1'b0, GEST_NONE},
    '{TYPE_ABS, CODE_TOUCH, 12'd0,      1'b0, GEST_NONE},
    '{TYPE_KEY, CODE_X,     12'd0,      1'b0, GEST_NONE},
    // displacement of exactly the threshold on both axes stays a tap
    '{TYPE_ABS, CODE_X,     12'd576,    1'b0, GEST_NONE},
    '{TYPE_ABS, CODE_Y,     12'd363,    1'b0, GEST_NONE},
    '{TYPE_KEY, CODE_TOUCH, TOUCH_UP,   1'b0, GEST_NONE}
  };

  // Fixed register settings; later phases draw random ones.
  logic [CfgW-1:0] thr_set   [5] = '{12'd0, 12'd4095, 12'd20,  12'd120, 12'd50};
  logic [CfgW-1:0] left_set  [5] = '{12'd0, 12'd4095, 12'd700, 12'd300, 12'd200};
  logic [CfgW-1:0] right_set [5] = '{12'd0, 12'd4095, 12'd100, 12'd500, 12'd600};

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0] cfg_index;
  logic [CfgW-1:0]    cfg_data;

  tgc_in_if  in_ch ();
  tgc_out_if out_ch ();

  touch_gesture_classifier_core i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #6 clk = ~clk;

  // Tracker state: scaled position, latched origin, and register copies.
  logic [PosW-1:0] now_px, now_py, org_px, org_py;
  logic [CfgW-1:0] swipe_thr, left_edge, right_edge;

  gesture_t gesture_q [$];
  int       mismatch_cnt = 0;
  int       quiet_cycles = 0;

  // Driver-to-monitor side info for the item on the bus (set at the falling
  // edge, read at the rising edge).
  bit       pinned_on = 1'b0;
  gesture_t pinned_gesture = GEST_NONE;

  int burst_left = 0;
  int raw_x = 0;
  int raw_y = 0;
  int phase_events;
  bit hold_off_req = 1'b0;

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  function automatic gesture_t classify_release();
    int dx, dy, ax, ay, thr;
    dx  = int'(now_px) - int'(org_px);
    dy  = int'(now_py) - int'(org_py);
    ax  = (dx < 0) ? -dx : dx;
    ay  = (dy < 0) ? -dy : dy;
    thr = int'(swipe_thr);
    if (ax > thr || ay > thr) begin
      // swipe: horizontal wins only when strictly larger
      if (ax > ay) begin
        if (dx > thr) return GEST_PREV;
        if (dx < -thr) return GEST_NEXT;
        return GEST_NONE;
      end
      return (ay > thr) ? GEST_TOGGLE : GEST_NONE;
    end
    // tap: left edge is tested first, so it wins when edges overlap
    if (org_px < left_edge) return GEST_PREV;
    if (org_px > right_edge) return GEST_NEXT;
    return GEST_NONE;
  endfunction

  // Advance the tracker by one event; return 1 when a gesture results.
  function automatic bit track_touch_event(input logic [TypeW-1:0] ev_t,
                                           input logic [CodeW-1:0] ev_c,
                                           input logic [ValueW-1:0] ev_v,
                                           output gesture_t g);
    int raw;
    raw = int'(ev_v);
    g   = GEST_NONE;
    if (ev_t == TYPE_ABS && ev_c == CODE_X) begin
      now_px = PosW'(raw * 800 / 1024);
    end else if (ev_t == TYPE_ABS && ev_c == CODE_Y) begin
      now_py = PosW'(raw * 480 / 600);
    end else if (ev_t == TYPE_KEY && ev_c == CODE_TOUCH) begin
      if (ev_v == TOUCH_DOWN) begin
        org_px = now_px;
        org_py = now_py;
      end else if (ev_v == TOUCH_UP) begin
        g = classify_release();
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // Check results and track accepted events at each rising edge. The result
  // handshake is handled first: any result leaving now belongs to an older
  // event than one accepted at the same edge.
  always @(posedge clk) begin : monitor
    gesture_t g;
    gesture_t want;
    bit       in_acc, out_acc;
    if (rst_n) begin
      in_acc  = in_ch.valid && in_ch.ready;
      out_acc = out_ch.valid && out_ch.ready;
      if (out_acc) begin
        if (gesture_q.size() == 0) begin
          report_mismatch($sformatf("gesture %0d with none expected", out_ch.gesture));
        end else begin
          want = gesture_q.pop_front();
          if (out_ch.gesture !== want)
            report_mismatch($sformatf("gesture %0d, expected %0d", out_ch.gesture, want));
        end
      end
      if (in_acc) begin
        if (track_touch_event(in_ch.event_type, in_ch.event_code, in_ch.event_value, g))
          gesture_q.push_back(pinned_on ? pinned_gesture : g);
      end
      quiet_cycles = (in_acc || out_acc) ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("[%0t] watchdog: no handshake for %0d cycles", $realtime, QuietLimit);
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Receiver: switch between always-ready, random stalls and a fixed
  // rotating pattern; on request, hold off for a long stretch so the core
  // fills up and backs up its input.
  initial begin : receiver
    int mode;
    int mode_left;
    int tick;
    logic [11:0] pattern;
    mode      = 0;
    mode_left = 0;
    tick      = 0;
    pattern   = 12'b1101_0011_1011;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (LongHold) @(negedge clk);
        hold_off_req = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = $urandom_range(0, 2);
          mode_left = $urandom_range(16, 128);
        end
        mode_left--;
        tick++;
        case (mode)
          0: out_ch.ready <= 1'b1;
          1: out_ch.ready <= ($urandom_range(0, 99) < 60);
          default: out_ch.ready <= pattern[4'(tick % 12)];
        endcase
      end
    end
  end

  // Offer one event; insert a random gap at the end of each burst. Hold
  // valid high across back-to-back items.
  task automatic push_event(input logic [TypeW-1:0] ev_t, input logic [CodeW-1:0] ev_c,
                            input logic [ValueW-1:0] ev_v, input bit pin = 1'b0,
                            input gesture_t pin_g = GEST_NONE);
    int gap;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 8);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 150)
                                               : $urandom_range(1, 16);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end else begin
      @(negedge clk);
    end
    burst_left--;
    pinned_on      = pin;
    pinned_gesture = pin_g;
    in_ch.valid       <= 1'b1;
    in_ch.event_type  <= ev_t;
    in_ch.event_code  <= ev_c;
    in_ch.event_value <= ev_v;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drop valid and wait until every expected gesture is out, then let the
  // pipeline empty of events that produce nothing.
  task automatic drain_core();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    burst_left = 0;
    while (gesture_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [CfgW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_SWIPE_MIN:       swipe_thr  = val;
      CFG_LEFT_TAP_EDGE:   left_edge  = val;
      CFG_RIGHT_TAP_EDGE:  right_edge = val;
      default: ;
    endcase
  endtask

  // Move a raw coordinate: either a small step around the current one or a
  // jump anywhere on the panel.
  function automatic int move_raw(input int cur);
    int nxt;
    if ($urandom_range(0, 1)) return $urandom_range(0, 4095);
    nxt = cur + $urandom_range(0, 200) - 100;
    if (nxt < 0) nxt = 0;
    if (nxt > 4095) nxt = 4095;
    return nxt;
  endfunction

  // Press, drag a little, release.
  task automatic send_touch_stroke();
    int moves;
    if ($urandom_range(0, 1)) begin
      raw_x = $urandom_range(0, 4095);
      raw_y = $urandom_range(0, 4095);
      push_event(TYPE_ABS, CODE_X, ValueW'(raw_x));
      push_event(TYPE_ABS, CODE_Y, ValueW'(raw_y));
      phase_events += 2;
    end
    push_event(TYPE_KEY, CODE_TOUCH, TOUCH_DOWN);
    moves = $urandom_range(0, 3);
    repeat (moves) begin
      if ($urandom_range(0, 1)) begin
        raw_x = move_raw(raw_x);
        push_event(TYPE_ABS, CODE_X, ValueW'(raw_x));
      end else begin
        raw_y = move_raw(raw_y);
        push_event(TYPE_ABS, CODE_Y, ValueW'(raw_y));
      end
    end
    push_event(TYPE_KEY, CODE_TOUCH, TOUCH_UP);
    phase_events += moves + 2;
  endtask

  initial begin : stimulus
    logic [CfgW-1:0] thr, l_edge, r_edge;
    int pick;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = CFG_SWIPE_MIN;
    cfg_data          = '0;
    in_ch.valid       = 1'b0;
    in_ch.event_type  = '0;
    in_ch.event_code  = '0;
    in_ch.event_value = '0;
    swipe_thr  = SWIPE_MIN_RST;
    left_edge  = LEFT_TAP_EDGE_RST;
    right_edge = RIGHT_TAP_EDGE_RST;
    now_px = '0;
    now_py = '0;
    org_px = '0;
    org_py = '0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the corner-case table at reset settings.
    foreach (corner_events[i])
      push_event(corner_events[i].ev_type, corner_events[i].ev_code,
                 corner_events[i].ev_value, corner_events[i].pinned,
                 corner_events[i].gesture);

    for (int ph = 0; ph < NumPhases; ph++) begin
      // Registers change only with the core idle.
      drain_core();
      if (ph < 5) begin
        thr    = thr_set[ph];
        l_edge = left_set[ph];
        r_edge = right_set[ph];
      end else begin
        thr    = CfgW'($urandom_range(0, 300));
        l_edge = CfgW'($urandom_range(0, 3300));
        r_edge = CfgW'($urandom_range(0, 3300));
      end
      write_reg(CFG_SWIPE_MIN, thr);
      write_reg(CFG_LEFT_TAP_EDGE, l_edge);
      write_reg(CFG_RIGHT_TAP_EDGE, r_edge);
      write_reg(CFG_UNUSED, CfgW'($urandom_range(0, 4095)));
      @(negedge clk);
      cfg_we <= 1'b0;

      // Back up the core once: the receiver stops while strokes keep coming.
      if (ph == 3) hold_off_req = 1'b1;

      phase_events = 0;
      while (phase_events < PhaseEvents) begin
        pick = $urandom_range(0, 99);
        if (pick < 75) begin
          send_touch_stroke();
        end else if (pick < 85) begin
          // pure noise over every bit of every field
          push_event(TypeW'($urandom_range(0, 31)), CodeW'($urandom_range(0, 1023)),
                     ValueW'($urandom_range(0, 4095)));
        end else if (pick < 92) begin
          // touch button with an invalid state value
          push_event(TYPE_KEY, CODE_TOUCH, ValueW'($urandom_range(2, 4095)));
        end else if (pick < 96) begin
          // orphan release
          push_event(TYPE_KEY, CODE_TOUCH, TOUCH_UP);
          phase_events++;
        end else begin
          // repeated press without release
          push_event(TYPE_KEY, CODE_TOUCH, TOUCH_DOWN);
          push_event(TYPE_KEY, CODE_TOUCH, TOUCH_DOWN);
          phase_events += 2;
        end
      end
    end

    drain_core();
    repeat (8) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
